FILE: sv/acl_rt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// acl_rt_pkg
// shared types and constants of the acl reassembly tracker
// ----------------------------------------------------------------------------
package acl_rt_pkg;

    localparam logic [1:0]  START_BOUNDARY = 2'd2;
    localparam logic [16:0] HEADERS_SIZE   = 17'd8;
    localparam logic [16:0] ACL_PREAMBLE   = 17'd4;
    localparam logic [15:0] MIN_START_LEN  = 16'd2;
    localparam logic [15:0] MAX_FULL_RESET = 16'd4104;

    typedef enum logic [2:0] {
        ACT_WHOLE        = 3'd0,
        ACT_STARTED      = 3'd1,
        ACT_APPENDED     = 3'd2,
        ACT_COMPLETED    = 3'd3,
        ACT_DROP_BCAST   = 3'd4,
        ACT_DROP_SHORT   = 3'd5,
        ACT_DROP_LONG    = 3'd6,
        ACT_DROP_UNKNOWN = 3'd7
    } action_t;

    // one context table entry
    typedef struct packed {
        logic        valid;
        logic [15:0] full;
        logic [15:0] fill;
    } ctx_t;

    typedef struct packed {
        logic en;
        ctx_t ctx;
    } ctx_wr_t;

    typedef struct packed {
        action_t     action;
        logic        old_dropped;
        logic        truncated;
        logic [15:0] write_offset;
        logic [15:0] copy_length;
        logic [15:0] frame_len;
    } result_t;

endpackage

FILE: sv/acl_reassembly_tracker_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// acl_reassembly_tracker_unit
// hci acl header tracker: per-handle reassembly context and copy decision
// ----------------------------------------------------------------------------
// sequence: the table is read at the accepting edge; the decision is then
//   registered with done while the context entry is written back
// throughput: one transaction per cycle while busy is low; the table read-modify-write
//   forwards the last written entry so back-to-back packets on one handle chain
// reset: busy stays high while the context table is swept clear one entry
//   a cycle; configuration writes are taken meanwhile
module acl_reassembly_tracker_unit #(
    parameter int HANDLE_BITS = 12
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [11:0] conn_handle,
    input  logic [1:0]  pb_flag,
    input  logic [1:0]  bc_flag,
    input  logic [15:0] data_len,
    input  logic [15:0] pdu_len,
    input  logic        cfg_wr_en,
    input  logic [15:0] cfg_wr_data,
    output logic        done,
    output logic [2:0]  action,
    output logic        old_dropped,
    output logic        truncated,
    output logic [15:0] write_offset,
    output logic [15:0] copy_length,
    output logic [15:0] frame_len
);

    logic                   accept;
    logic [15:0]            max_full_reg;

    logic                   clr_busy_reg;
    logic [HANDLE_BITS-1:0] clr_addr_reg;

    logic                   s1_valid_reg;
    logic [HANDLE_BITS-1:0] s1_handle_reg;
    logic [1:0]             s1_boundary_reg;
    logic [1:0]             s1_bcast_reg;
    logic [15:0]            s1_acl_reg;
    logic [15:0]            s1_l2_reg;

    logic                   fwd_valid_reg;
    logic [HANDLE_BITS-1:0] fwd_addr_reg;
    acl_rt_pkg::ctx_t       fwd_ctx_reg;

    acl_rt_pkg::ctx_t       rd_ctx;
    acl_rt_pkg::ctx_t       cur_ctx;
    acl_rt_pkg::result_t    res;
    acl_rt_pkg::ctx_wr_t    upd;

    logic                   mem_wr_en;
    logic [HANDLE_BITS-1:0] mem_wr_addr;
    acl_rt_pkg::ctx_t       mem_wr_data;

    logic                   done_reg;
    acl_rt_pkg::result_t    res_reg;

    assign busy   = clr_busy_reg;
    assign accept = start && !clr_busy_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_full_reg <= acl_rt_pkg::MAX_FULL_RESET;
        end
        else if (cfg_wr_en)
        begin
            max_full_reg <= cfg_wr_data;
        end
    end

    // clearing sweep after reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_busy_reg <= 1'b1;
            clr_addr_reg <= '0;
        end
        else if (clr_busy_reg)
        begin
            clr_addr_reg <= clr_addr_reg + 1'b1;
            if (clr_addr_reg == {HANDLE_BITS{1'b1}})
            begin
                clr_busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            fwd_valid_reg <= 1'b0;
            done_reg      <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= accept;
            fwd_valid_reg <= s1_valid_reg && upd.en;
            done_reg      <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_handle_reg   <= conn_handle[HANDLE_BITS-1:0];
            s1_boundary_reg <= pb_flag;
            s1_bcast_reg    <= bc_flag;
            s1_acl_reg      <= data_len;
            s1_l2_reg       <= pdu_len;
        end
        fwd_addr_reg <= s1_handle_reg;
        fwd_ctx_reg  <= upd.ctx;
        if (s1_valid_reg)
        begin
            res_reg <= res;
        end
    end

    acl_rt_ctx_mem #(
        .ADDR_BITS (HANDLE_BITS)
    ) u_ctx_mem (
        .clk     (clk),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .rd_en   (accept),
        .rd_addr (conn_handle[HANDLE_BITS-1:0]),
        .rd_data (rd_ctx)
    );

    // entry written on the edge that read this one is not yet in the read data
    assign cur_ctx = (fwd_valid_reg && (fwd_addr_reg == s1_handle_reg)) ? fwd_ctx_reg : rd_ctx;

    acl_rt_decide u_decide (
        .ctx      (cur_ctx),
        .pb_flag  (s1_boundary_reg),
        .bc_flag  (s1_bcast_reg),
        .data_len (s1_acl_reg),
        .pdu_len  (s1_l2_reg),
        .max_full (max_full_reg),
        .res      (res),
        .wr       (upd)
    );

    assign mem_wr_en   = clr_busy_reg || (s1_valid_reg && upd.en);
    assign mem_wr_addr = clr_busy_reg ? clr_addr_reg : s1_handle_reg;
    assign mem_wr_data = clr_busy_reg ? acl_rt_pkg::ctx_t'('0) : upd.ctx;

    assign done         = done_reg;
    assign action       = res_reg.action;
    assign old_dropped  = res_reg.old_dropped;
    assign truncated    = res_reg.truncated;
    assign write_offset = res_reg.write_offset;
    assign copy_length  = res_reg.copy_length;
    assign frame_len    = res_reg.frame_len;

`ifndef SYNTHESIS
    a_one_result_per_transaction: assert property (
        @(posedge clk) disable iff (!rst_n) s1_valid_reg |=> done_reg
    ) else $error("transaction lost its result");

    a_no_work_while_clearing: assert property (
        @(posedge clk) disable iff (!rst_n) clr_busy_reg |-> !s1_valid_reg
    ) else $error("transaction in flight during table clear");

    a_drop_fields_zero: assert property (
        @(posedge clk) disable iff (!rst_n)
        (done_reg && res_reg.action[2]) |->
            (res_reg.write_offset == 16'd0 && res_reg.copy_length == 16'd0
             && res_reg.frame_len == 16'd0 && !res_reg.truncated)
    ) else $error("drop result carries nonzero lengths");
`endif

endmodule

FILE: sv/acl_rt_ctx_mem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// acl_rt_ctx_mem
// context table: one write port, one read port with registered read data
// ----------------------------------------------------------------------------
module acl_rt_ctx_mem #(
    parameter int ADDR_BITS = 12
) (
    input  logic                  clk,
    input  logic                  wr_en,
    input  logic [ADDR_BITS-1:0]  wr_addr,
    input  acl_rt_pkg::ctx_t      wr_data,
    input  logic                  rd_en,
    input  logic [ADDR_BITS-1:0]  rd_addr,
    output acl_rt_pkg::ctx_t      rd_data
);

    localparam int DEPTH = 1 << ADDR_BITS;

    acl_rt_pkg::ctx_t mem [DEPTH];
    acl_rt_pkg::ctx_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: sv/acl_rt_decide.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// acl_rt_decide
// per-packet decision and context update from the header and the old context
// ----------------------------------------------------------------------------
module acl_rt_decide (
    input  acl_rt_pkg::ctx_t    ctx,
    input  logic [1:0]          pb_flag,
    input  logic [1:0]          bc_flag,
    input  logic [15:0]         data_len,
    input  logic [15:0]         pdu_len,
    input  logic [15:0]         max_full,
    output acl_rt_pkg::result_t res,
    output acl_rt_pkg::ctx_wr_t wr
);

    logic [16:0] want;
    logic [16:0] pkt_len;
    logic [15:0] room;
    logic [16:0] next_fill;

    assign want    = {1'b0, pdu_len} + acl_rt_pkg::HEADERS_SIZE;
    assign pkt_len = {1'b0, data_len} + acl_rt_pkg::ACL_PREAMBLE;
    assign room    = (ctx.full > ctx.fill) ? (ctx.full - ctx.fill) : 16'd0;

    always_comb
    begin
        res        = '0;
        res.action = acl_rt_pkg::ACT_DROP_BCAST;
        wr.en      = 1'b0;
        wr.ctx     = ctx;
        next_fill  = {1'b0, ctx.fill};
        if (bc_flag != 2'd0)
        begin
            res.action = acl_rt_pkg::ACT_DROP_BCAST;
        end
        else if (pb_flag == acl_rt_pkg::START_BOUNDARY)
        begin
            if (data_len < acl_rt_pkg::MIN_START_LEN)
            begin
                res.action = acl_rt_pkg::ACT_DROP_SHORT;
            end
            else
            begin
                // any open context on this handle is thrown away
                res.old_dropped = ctx.valid;
                wr.en           = 1'b1;
                wr.ctx.valid    = 1'b0;
                if (want[16] || (want > {1'b0, max_full}))
                begin
                    res.action = acl_rt_pkg::ACT_DROP_LONG;
                end
                else if (want <= pkt_len)
                begin
                    res.action      = acl_rt_pkg::ACT_WHOLE;
                    res.copy_length = pkt_len[16] ? 16'hFFFF : pkt_len[15:0];
                    res.frame_len   = want[15:0];
                end
                else
                begin
                    res.action      = acl_rt_pkg::ACT_STARTED;
                    res.copy_length = pkt_len[15:0];
                    res.frame_len   = want[15:0];
                    wr.ctx.valid    = 1'b1;
                    wr.ctx.full     = want[15:0];
                    wr.ctx.fill     = pkt_len[15:0];
                end
            end
        end
        else if (!ctx.valid)
        begin
            res.action = acl_rt_pkg::ACT_DROP_UNKNOWN;
        end
        else
        begin
            wr.en            = 1'b1;
            res.write_offset = ctx.fill;
            res.frame_len    = ctx.full;
            if (data_len > room)
            begin
                res.truncated   = 1'b1;
                res.copy_length = room;
                next_fill       = {1'b0, ctx.full};
            end
            else
            begin
                res.copy_length = data_len;
                next_fill       = {1'b0, ctx.fill} + {1'b0, data_len};
            end
            if (next_fill == {1'b0, ctx.full})
            begin
                res.action   = acl_rt_pkg::ACT_COMPLETED;
                wr.ctx.valid = 1'b0;
                wr.ctx.fill  = 16'd0;
            end
            else
            begin
                res.action  = acl_rt_pkg::ACT_APPENDED;
                wr.ctx.fill = next_fill[15:0];
            end
        end
    end

endmodule
